// ===== rtl/core/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Types, constants and command/status records shared by the spanning tree block.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int MAX_EDGES_DEF    = 64;
	localparam int MAX_VERTICES_DEF = 32;
	localparam int WEIGHT_BITS_DEF  = 16;
	localparam int VERTEX_BITS      = $clog2(MAX_VERTICES_DEF);
	localparam int WEIGHT_W         = WEIGHT_BITS_DEF;
	localparam int COUNT_BITS       = 6;
	localparam int RANK_BITS        = 3;
	localparam int MAX_ACCEPT       = 31;
	localparam int ACC_BITS         = 5;
	localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = 6'd32;

	// input word
	typedef struct packed {
		logic [VERTEX_BITS-1:0]  from_vertex;
		logic [VERTEX_BITS-1:0]  to_vertex;
		logic signed [WEIGHT_W-1:0] edge_weight;
		logic                    last_edge;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [VERTEX_BITS-1:0]  tree_from;
		logic [VERTEX_BITS-1:0]  tree_to;
		logic signed [WEIGHT_W-1:0] tree_weight;
		logic                    edge_present;
		logic                    spanning;
		logic                    dropped;
		logic                    last_result;
	} out_word_t;

	// datapath operations
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_SCAN    = 4'd2;  // read candidate edge i
	localparam logic [3:0] OP_CAPT    = 4'd3;  // compare/capture minimum
	localparam logic [3:0] OP_PICK    = 4'd4;  // read chosen edge
	localparam logic [3:0] OP_FINDA   = 4'd5;
	localparam logic [3:0] OP_FINDB   = 4'd6;
	localparam logic [3:0] OP_MERGE   = 4'd7;
	localparam logic [3:0] OP_EMIT    = 4'd8;
	localparam logic [3:0] OP_EMPTY   = 4'd9;
	localparam logic [3:0] OP_CLEAR   = 4'd10;
	localparam logic [3:0] OP_SETLAST = 4'd11;
	localparam logic [3:0] OP_FETCH   = 4'd12; // read accepted edge for output
	localparam logic [3:0] OP_NEXT    = 4'd13; // output word taken, step on

	typedef struct packed {
		logic [3:0] op;
	} mst_cmd_t;

	typedef struct packed {
		logic scan_done;    // all stored edges visited in this pass
		logic found;        // a not yet used edge was found
		logic root_a_done;
		logic root_b_done;
		logic differ;       // roots differ and fewer than 31 accepted
		logic clear_done;
		logic none_acc;     // no edge accepted yet
		logic load_last;    // loaded word was last
		logic emit_last;    // word on output is the final accepted edge
	} mst_stat_t;

endpackage

// ===== rtl/core/mst_ram.sv =====
// ----------------------------------------------------------------------------
// mst_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/mst_datapath.sv =====
// ----------------------------------------------------------------------------
// mst_datapath
// Edge store, used-edge marks, minimum search and union-find walk.
// ----------------------------------------------------------------------------
module mst_datapath #(
	parameter int MAX_EDGES    = 64,
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mst_pkg::mst_cmd_t       cmd,
	input  mst_pkg::in_word_t       in_word,
	input  logic [mst_pkg::COUNT_BITS-1:0] vertex_count,
	output mst_pkg::mst_stat_t      stat,
	output mst_pkg::out_word_t      res
);
	import mst_pkg::*;

	localparam int EA = $clog2(MAX_EDGES);
	localparam int VA = $clog2(MAX_VERTICES);
	localparam int RW = 2 * VERTEX_BITS + WEIGHT_BITS;

	logic [EA:0] edge_total_q;
	logic        drop_q;
	logic        last_q;
	logic [MAX_EDGES-1:0] used_q;
	logic [EA:0] idx_q;
	logic [EA:0] best_q;
	logic        have_q;
	logic signed [WEIGHT_BITS-1:0] best_w_q;
	logic [EA-1:0] ram_ra;
	logic [RW-1:0] ram_rd;
	logic          ram_we;
	logic [RW-1:0] ram_wd;
	logic [EA:0]   cap_idx_q;   // index of word read last cycle
	logic [VA-1:0] par_q [MAX_VERTICES];
	logic [RANK_BITS-1:0] rank_q [MAX_VERTICES];
	logic [VA-1:0] ra_q, rb_q;
	logic [EA-1:0] acc_idx_q [MAX_ACCEPT];  // accepted edges in order
	logic [ACC_BITS-1:0] emit_q;
	logic [VA:0]   walk_q;
	logic [5:0]    acc_q;
	logic [VA:0]   clr_q;
	logic [COUNT_BITS-1:0] nv;
	logic          in_ok;
	logic [VERTEX_BITS-1:0] rd_from, rd_to;
	logic signed [WEIGHT_BITS-1:0] rd_w;

	// effective vertex count
	always_comb begin
		if (vertex_count == '0) nv = COUNT_BITS'(1);
		else if (32'(vertex_count) > MAX_VERTICES) nv = COUNT_BITS'(MAX_VERTICES);
		else nv = vertex_count;
	end

	assign in_ok = (COUNT_BITS'(in_word.from_vertex) < nv) &&
		(COUNT_BITS'(in_word.to_vertex) < nv) &&
		(32'(edge_total_q) < MAX_EDGES);
	assign ram_we = (cmd.op == OP_LOAD) && in_ok;
	assign ram_wd = {in_word.from_vertex, in_word.to_vertex,
		WEIGHT_BITS'(in_word.edge_weight)};
	assign {rd_from, rd_to, rd_w} = ram_rd;

	// read address: scan index, chosen edge or accepted edge being output
	always_comb begin
		case (cmd.op)
			OP_PICK: ram_ra = best_q[EA-1:0];
			OP_FETCH, OP_EMIT, OP_NEXT: ram_ra = acc_idx_q[emit_q];
			default: ram_ra = idx_q[EA-1:0];
		endcase
	end

	mst_ram #(.WIDTH(RW), .DEPTH(MAX_EDGES)) u_store (
		.clk(clk), .we(ram_we), .waddr(edge_total_q[EA-1:0]), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	// status
	always_comb begin
		stat.scan_done   = (idx_q >= edge_total_q);
		stat.found       = have_q;
		stat.root_a_done = (par_q[ra_q] == ra_q);
		stat.root_b_done = (par_q[rb_q] == rb_q);
		stat.differ      = (ra_q != rb_q) && (acc_q < 6'd31);
		stat.clear_done  = (32'(clr_q) >= MAX_VERTICES - 1);
		stat.none_acc    = (acc_q == '0);
		stat.load_last   = last_q;
		stat.emit_last   = (COUNT_BITS'(emit_q) + COUNT_BITS'(1) == acc_q);
	end

	// result word, zero fields for an empty tree
	always_comb begin
		res.tree_from    = (cmd.op == OP_EMPTY) ? '0 : rd_from;
		res.tree_to      = (cmd.op == OP_EMPTY) ? '0 : rd_to;
		res.tree_weight  = (cmd.op == OP_EMPTY) ? '0 : WEIGHT_W'(rd_w);
		res.edge_present = (cmd.op != OP_EMPTY);
		res.spanning     = (acc_q == 6'(nv - 1'b1));
		res.dropped      = drop_q;
		res.last_result  = 1'b0;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			drop_q <= 1'b0;
			last_q <= 1'b0;
			used_q <= '0;
			idx_q <= '0;
			have_q <= 1'b0;
			acc_q <= '0;
			clr_q <= '0;
			walk_q <= '0;
			emit_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (in_ok) edge_total_q <= edge_total_q + 1'b1;
					else drop_q <= 1'b1;
					last_q <= in_word.last_edge;
					idx_q <= '0;
					have_q <= 1'b0;
				end
				OP_SCAN: begin
					idx_q <= idx_q + 1'b1;
				end
				OP_CAPT: begin
					if (!used_q[cap_idx_q[EA-1:0]] &&
						(!have_q || rd_w < best_w_q)) begin
						have_q <= 1'b1;
					end
				end
				OP_PICK: begin
					used_q[best_q[EA-1:0]] <= 1'b1;
					walk_q <= '0;
				end
				OP_FINDA, OP_FINDB: walk_q <= walk_q + 1'b1;
				OP_MERGE: begin
					if (stat.differ) acc_q <= acc_q + 1'b1;
					idx_q <= '0;
					have_q <= 1'b0;
				end
				OP_NEXT: emit_q <= emit_q + 1'b1;
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_SETLAST: begin
					edge_total_q <= '0;
					drop_q <= 1'b0;
					last_q <= 1'b0;
					used_q <= '0;
					acc_q <= '0;
					clr_q <= '0;
					idx_q <= '0;
					have_q <= 1'b0;
					emit_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// union-find tables, cleared by a sweep whose last entry goes with setlast
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < MAX_VERTICES; v++) begin
				par_q[v] <= VA'(v);
				rank_q[v] <= '0;
			end
		end else if (cmd.op == OP_CLEAR || cmd.op == OP_SETLAST) begin
			par_q[clr_q[VA-1:0]] <= clr_q[VA-1:0];
			rank_q[clr_q[VA-1:0]] <= '0;
		end else if (cmd.op == OP_MERGE && stat.differ) begin
			if (rank_q[ra_q] > rank_q[rb_q]) par_q[rb_q] <= ra_q;
			else begin
				par_q[ra_q] <= rb_q;
				if (rank_q[ra_q] == rank_q[rb_q]) rank_q[rb_q] <= rank_q[rb_q] + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cap_idx_q <= idx_q;
		case (cmd.op)
			OP_CAPT: begin
				if (!used_q[cap_idx_q[EA-1:0]] && (!have_q || rd_w < best_w_q)) begin
					best_q <= cap_idx_q;
					best_w_q <= rd_w;
				end
			end
			OP_FINDA: begin
				if (walk_q == '0) begin
					ra_q <= VA'(rd_from);
					rb_q <= VA'(rd_to);
				end else ra_q <= par_q[ra_q];
			end
			OP_FINDB: rb_q <= par_q[rb_q];
			OP_MERGE: begin
				if (stat.differ) acc_idx_q[acc_q[ACC_BITS-1:0]] <= best_q[EA-1:0];
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/mst_ctrl.sv =====
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer: load, repeated minimum scan, root walks, merge and emit.
// ----------------------------------------------------------------------------
module mst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               out_last,
	input  mst_pkg::mst_stat_t stat,
	output mst_pkg::mst_cmd_t  cmd
);
	import mst_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_CAPT = 4'd2,
		S_PICK = 4'd3, S_FA0 = 4'd4, S_FA = 4'd5, S_FB = 4'd6, S_MRG = 4'd7,
		S_EMIT = 4'd8, S_EMPTY = 4'd9, S_CLR = 4'd10, S_DONE = 4'd11,
		S_FIN = 4'd12, S_FETCH = 4'd13;

	logic [3:0] state_q, state_d;

	// sequencing
	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		in_stall = 1'b1;
		out_valid = 1'b0;
		out_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = stat.load_last ? S_SCAN : S_IDLE;
			S_SCAN: begin
				if (stat.scan_done) state_d = stat.found ? S_PICK : S_FIN;
				else begin
					cmd.op = OP_SCAN;
					state_d = S_CAPT;
				end
			end
			S_CAPT: begin
				cmd.op = OP_CAPT;
				state_d = S_SCAN;
			end
			S_PICK: begin
				cmd.op = OP_PICK;
				state_d = S_FA0;
			end
			S_FA0: begin
				cmd.op = OP_FINDA;
				state_d = S_FA;
			end
			S_FA: begin
				if (stat.root_a_done) state_d = S_FB;
				else cmd.op = OP_FINDA;
			end
			S_FB: begin
				if (stat.root_b_done) state_d = S_MRG;
				else cmd.op = OP_FINDB;
			end
			S_MRG: begin
				cmd.op = OP_MERGE;
				state_d = S_SCAN;
			end
			S_FIN: state_d = stat.none_acc ? S_EMPTY : S_FETCH;
			// replay accepted edges once the tree is complete
			S_FETCH: begin
				cmd.op = OP_FETCH;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				out_valid = 1'b1;
				out_last = stat.emit_last;
				cmd.op = OP_EMIT;
				if (!out_stall) begin
					if (stat.emit_last) state_d = S_CLR;
					else begin
						cmd.op = OP_NEXT;
						state_d = S_FETCH;
					end
				end
			end
			S_EMPTY: begin
				out_valid = 1'b1;
				out_last = 1'b1;
				cmd.op = OP_EMPTY;
				if (!out_stall) state_d = S_CLR;
			end
			S_CLR: begin
				if (stat.clear_done) begin
					cmd.op = OP_SETLAST;
					state_d = S_IDLE;
				end else cmd.op = OP_CLEAR;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== rtl/core/minimum_spanning_tree_kruskal.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal spanning tree over loaded edges with union-find by rank.
// ----------------------------------------------------------------------------
// Edges are loaded one word at a time into an edge RAM; after each load
// the input stalls for the DONE state. The word flagged last_edge starts a
// run: for each tree step the sequencer scans every stored edge (a SCAN and
// a CAPT state per edge, as the RAM read is registered) for the lightest
// unused one, earliest on ties, then walks both parent chains one link a
// cycle and merges roots. Each accepted edge is then output through a FETCH
// and an EMIT state (EMIT holds under stalls), followed by a union-find
// clearing sweep. Accepted edges are kept in order and replayed once the
// tree is complete, so every word carries the final spanning flag; an empty
// tree gives one word with edge_present low.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal #(
	parameter int MAX_EDGES    = mst_pkg::MAX_EDGES_DEF,
	parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mst_pkg::in_word_t     in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mst_pkg::out_word_t    out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [mst_pkg::COUNT_BITS-1:0] cfg_data
);
	import mst_pkg::*;

	logic [COUNT_BITS-1:0] vcount_q;
	mst_cmd_t  cmd;
	mst_stat_t stat;
	out_word_t res;
	logic      out_last;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= VERTEX_COUNT_RESET;
		else if (cfg_valid) vcount_q <= cfg_data;
	end

	mst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .out_last(out_last),
		.stat(stat), .cmd(cmd)
	);

	mst_datapath #(
		.MAX_EDGES(MAX_EDGES), .MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_data),
		.vertex_count(vcount_q), .stat(stat), .res(res)
	);

	// result word with last flag
	always_comb begin
		out_data = res;
		out_data.last_result = out_last;
	end

	// no load taken while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall)) else $error("load during output");
	// an empty tree word is always the last word
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.edge_present) |-> out_data.last_result)
		else $error("empty word not last");
	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

// ===== tb/sv/tb_minimum_spanning_tree_kruskal.sv =====
// ----------------------------------------------------------------------------
// tb_minimum_spanning_tree_kruskal
// Self-checking bench for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
// Graphs are sent edge by edge with random gaps and result stalls. A local
// model sorts the stored edges stably by weight and runs union-find by rank,
// queueing the expected tree words, which a checker compares as they arrive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_minimum_spanning_tree_kruskal;
	import mst_pkg::*;

	localparam int EDGE_CAP = 64;
	localparam int VERT_CAP = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [COUNT_BITS-1:0] cfg_data = '0;

	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int graphs_run = 0;
	bit quiet_mode = 1'b0;

	// model state
	in_word_t graph_edges[EDGE_CAP];
	int edge_count = 0;
	bit drop_flag = 1'b0;
	logic [COUNT_BITS-1:0] vcount_reg = VERTEX_COUNT_RESET;
	out_word_t tree_queue[$];

	minimum_spanning_tree_kruskal DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// generous run limit
	initial begin
		#400ms;
		$display("[minimum_spanning_tree_kruskal] ERROR");
		$finish;
	end

	function automatic int live_vertices();
		if (vcount_reg == 0) return 1;
		if (vcount_reg > VERT_CAP) return VERT_CAP;
		return vcount_reg;
	endfunction

	function automatic int find_root(ref logic [4:0] par[VERT_CAP], input int v);
		for (int s = 0; s < VERT_CAP; s++) begin
			if (par[v] == v) break;
			v = par[v];
		end
		return v;
	endfunction

	// absorb one edge and, on the last one, build the expected tree
	task automatic build_tree(input in_word_t w);
		int nv, acc, cnt, cur, j, ra, rb;
		int order[EDGE_CAP];
		logic [4:0] par[VERT_CAP];
		logic [2:0] rnk[VERT_CAP];
		out_word_t res[$];
		out_word_t r;
		nv = live_vertices();
		if (w.from_vertex >= nv || w.to_vertex >= nv || edge_count >= EDGE_CAP)
			drop_flag = 1'b1;
		else begin
			graph_edges[edge_count] = w;
			edge_count++;
		end
		if (!w.last_edge) return;
		// stable insertion sort by signed weight
		for (int i = 0; i < edge_count; i++) begin
			j = i;
			while (j > 0 && graph_edges[order[j-1]].edge_weight > graph_edges[i].edge_weight) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < VERT_CAP; i++) begin
			par[i] = i[4:0];
			rnk[i] = '0;
		end
		acc = 0;
		for (int i = 0; i < edge_count; i++) begin
			cur = order[i];
			ra = find_root(par, graph_edges[cur].from_vertex);
			rb = find_root(par, graph_edges[cur].to_vertex);
			if (ra != rb && acc < 31) begin
				if (rnk[ra] > rnk[rb]) par[rb] = ra[4:0];
				else if (rnk[ra] < rnk[rb]) par[ra] = rb[4:0];
				else begin
					par[ra] = rb[4:0];
					rnk[rb] = rnk[rb] + 3'd1;
				end
				r = '0;
				r.tree_from = graph_edges[cur].from_vertex;
				r.tree_to = graph_edges[cur].to_vertex;
				r.tree_weight = graph_edges[cur].edge_weight;
				r.edge_present = 1'b1;
				res.push_back(r);
				acc++;
			end
		end
		if (acc == 0) res.push_back('0);
		cnt = res.size();
		for (int i = 0; i < cnt; i++) begin
			r = res[i];
			r.spanning = (acc == nv - 1);
			r.dropped = drop_flag;
			r.last_result = (i == cnt - 1);
			tree_queue.push_back(r);
		end
		edge_count = 0;
		drop_flag = 1'b0;
		graphs_run++;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch on %s: got %0d, want %0d", what, got, want);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (quiet_mode) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < 37);
	end

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tree_queue.size() == 0) begin
				report_mismatch("unexpected result word", 1, 0);
			end else begin
				want = tree_queue.pop_front();
				words_checked++;
				if (out_data.tree_from !== want.tree_from)
					report_mismatch("tree_from", out_data.tree_from, want.tree_from);
				if (out_data.tree_to !== want.tree_to)
					report_mismatch("tree_to", out_data.tree_to, want.tree_to);
				if (out_data.tree_weight !== want.tree_weight)
					report_mismatch("tree_weight", out_data.tree_weight, want.tree_weight);
				if (out_data.edge_present !== want.edge_present)
					report_mismatch("edge_present", out_data.edge_present, want.edge_present);
				if (out_data.spanning !== want.spanning)
					report_mismatch("spanning", out_data.spanning, want.spanning);
				if (out_data.dropped !== want.dropped)
					report_mismatch("dropped", out_data.dropped, want.dropped);
				if (out_data.last_result !== want.last_result)
					report_mismatch("last_result", out_data.last_result, want.last_result);
			end
		end
	end

	// send one edge word, with an optional random gap first
	task automatic send_edge(input int fv, input int tv, input int wt, input bit last);
		in_word_t w;
		w.from_vertex = fv[4:0];
		w.to_vertex = tv[4:0];
		w.edge_weight = wt[15:0];
		w.last_edge = last;
		// the block stalls the cycle after a load, so this edge costs nothing
		@(posedge clk);
		while (!quiet_mode && $urandom_range(99) < 37) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		build_tree(w);
		words_sent++;
		in_valid <= 1'b0;
	endtask

	// drain results, then allow the clearing sweep to finish
	task automatic wait_idle();
		while (tree_queue.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_vertex_count(input int n);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= n[COUNT_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		vcount_reg = n[COUNT_BITS-1:0];
	endtask

	task automatic test_directed();
		// lone self loop gives an empty tree
		send_edge(3, 3, 5, 1'b1);
		// extreme weights, tie kept in load order, highest vertex index
		send_edge(0, 31, 32767, 1'b0);
		send_edge(31, 1, -32768, 1'b0);
		send_edge(1, 2, 7, 1'b0);
		send_edge(2, 0, 7, 1'b0);
		send_edge(0, 1, -1, 1'b1);
		// small graph that spans
		write_vertex_count(4);
		send_edge(0, 1, 1, 1'b0);
		send_edge(1, 2, 2, 1'b0);
		send_edge(2, 3, 3, 1'b0);
		send_edge(0, 9, 0, 1'b0);
		send_edge(3, 0, 0, 1'b1);
		// a dropped last edge still runs
		send_edge(0, 2, 4, 1'b0);
		send_edge(5, 1, 4, 1'b1);
		// vertex count of zero acts as one
		write_vertex_count(0);
		send_edge(0, 0, 10, 1'b0);
		send_edge(0, 1, 10, 1'b1);
		// above the capacity acts as the capacity
		write_vertex_count(63);
		send_edge(30, 31, -5, 1'b1);
	endtask

	task automatic test_store_full();
		// overflow the edge store with a chain across all vertices
		write_vertex_count(32);
		for (int i = 0; i < 66; i++)
			send_edge(i % 32, (i + 1) % 32, $urandom_range(65535), i == 65);
	endtask

	task automatic test_random_graphs();
		int nv, ne, fv, tv;
		for (int g = 0; g < 50; g++) begin
			if (g % 8 == 0) begin
				nv = (g == 16) ? 1 : $urandom_range(2, 12);
				if (g == 24) nv = 32;
				write_vertex_count(nv);
			end
			if (g >= 10 && g < 16) quiet_mode = 1'b1;
			else quiet_mode = 1'b0;
			ne = $urandom_range(1, 10);
			for (int e = 0; e < ne; e++) begin
				// mostly in range, occasionally any vertex
				if ($urandom_range(9) == 0) begin
					fv = $urandom_range(31);
					tv = $urandom_range(31);
				end else begin
					fv = $urandom_range(live_vertices() - 1);
					tv = $urandom_range(live_vertices() - 1);
				end
				send_edge(fv, tv, ($urandom_range(3) == 0) ? $urandom_range(3) :
					$urandom_range(65535), e == ne - 1);
			end
			// once, hold off until all results are in
			if (g == 20) while (tree_queue.size() != 0) @(posedge clk);
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (40) @(posedge clk);
		test_directed();
		test_store_full();
		test_random_graphs();
		wait_idle();
		$display("sent %0d edge words over %0d graphs, checked %0d tree words",
			words_sent, graphs_run, words_checked);
		$display("covered self loops, drops, store overflow, ties and vertex count limits");
		if (errors == 0 && tree_queue.size() == 0)
			$display("[minimum_spanning_tree_kruskal] OK");
		else
			$display("[minimum_spanning_tree_kruskal] ERROR");
		$finish;
	end

endmodule
